// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication violated.");

// The consequent must hold in the cycle after the antecedent.
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication violated.");

`endif

// ===== rtl/core/teq_pkg.sv =====
// Types and constants for the stable time-ordered event queue.
`timescale 1ns / 1ps
package teq_pkg;

    // Default number of slots in the queue.
    localparam int TEQ_DEPTH = 16;

    localparam int TIME_W = 31;
    localparam int KIND_W = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_teq_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEGATIVE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_teq_status;

    // Operation applied to every cell of the chain in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_teq_op;

    typedef struct packed {
        t_teq_cmd           command;
        logic signed [31:0] event_time;
        logic [KIND_W-1:0]  event_kind;
    } t_teq_in;

    typedef struct packed {
        t_teq_status       status;
        logic [TIME_W-1:0] out_time;
        logic [KIND_W-1:0] out_kind;
    } t_teq_out;

    // One stored event.
    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [KIND_W-1:0] ev_kind;
    } t_teq_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        t_teq_op    op;
        t_teq_entry new_entry;
    } t_teq_ctl;

endpackage

// ===== rtl/core/teq_cell.sv =====
// One slot of the sorted shift-register chain.
`timescale 1ns / 1ps
module teq_cell
    import teq_pkg::*;
(
    input  logic       i_clk,
    input  t_teq_ctl   i_ctl,
    input  logic       i_occ,
    input  logic       i_left_keep,
    input  t_teq_entry i_left,
    input  t_teq_entry i_right,
    output logic       o_keep,
    output t_teq_entry o_entry
);

    t_teq_entry r_entry;
    t_teq_entry n_entry;

    // An occupied slot whose time is not later than the new event stays put.
    assign o_keep  = i_occ && (r_entry.ev_time <= i_ctl.new_entry.ev_time);
    assign o_entry = r_entry;

    // Insert: keep, take the new event at the boundary, or shift right.
    // Remove: every slot but the last takes its right neighbor; the last keeps its own.
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_keep) begin
                    n_entry = r_entry;
                end else if (i_left_keep) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_left;
                end
            end
            OP_REMOVE: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/core/stable_time_ordered_event_queue.sv =====
// Top level of the stable time-ordered event queue.
// An accepted request's result is in the output register in the following cycle.
// One request per cycle unless stalled; every slot cell compares and shifts in parallel.
// The input stalls only while a finished result waits and the output is stalled.
// Reset clears the fill count and the output valid; slot contents are left as they are.
`timescale 1ns / 1ps
module stable_time_ordered_event_queue
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = TEQ_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_teq_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_teq_out o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_teq_out         r_out;
    t_teq_out         n_out;

    logic       accept;
    logic       is_neg;
    logic       is_full;
    logic       is_empty;
    t_teq_ctl   ctl;
    logic       keep  [QUEUE_DEPTH];
    t_teq_entry entry [QUEUE_DEPTH];

    // A new request enters unless a result is waiting on a stalled output.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_neg   = i_in.event_time[31];
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    // Decode the request into the operation for the chain.
    always_comb begin
        ctl.new_entry.ev_time = i_in.event_time[TIME_W-1:0];
        ctl.new_entry.ev_kind = i_in.event_kind;
        ctl.op                = OP_HOLD;
        if (accept) begin
            case (i_in.command)
                CMD_INSERT: begin
                    if (!is_neg && !is_full) begin
                        ctl.op = OP_INSERT;
                    end
                end
                CMD_REMOVE: begin
                    if (!is_empty) begin
                        ctl.op = OP_REMOVE;
                    end
                end
                default: begin
                    ctl.op = OP_HOLD;
                end
            endcase
        end
    end

    // Chain of slot cells, slot 0 holding the earliest event.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic       left_keep;
        t_teq_entry left_entry;
        t_teq_entry right_entry;

        if (g == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_entry = ctl.new_entry;
        end else begin : g_mid
            assign left_keep  = keep[g-1];
            assign left_entry = entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = entry[g];
        end else begin : g_inner
            assign right_entry = entry[g+1];
        end

        teq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (r_count > CNT_W'(g)),
            .i_left_keep (left_keep),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_keep      (keep[g]),
            .o_entry     (entry[g])
        );
    end

    // Fill count follows the operation applied to the chain.
    always_comb begin
        case (ctl.op)
            OP_INSERT: n_count = r_count + 1'b1;
            OP_REMOVE: n_count = r_count - 1'b1;
            default:   n_count = r_count;
        endcase
    end

    // Result of the accepted request.
    always_comb begin
        n_out.status   = ST_OK;
        n_out.out_time = '0;
        n_out.out_kind = '0;
        if (i_in.command == CMD_INSERT) begin
            if (is_neg) begin
                n_out.status = ST_NEGATIVE;
            end else if (is_full) begin
                n_out.status = ST_FULL;
            end
        end else if (is_empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.out_time = entry[0].ev_time;
            n_out.out_kind = entry[0].ev_kind;
        end
    end

    assign n_out_valid = accept || (r_out_valid && i_out_stall);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register loads on every accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/teq_checker.sv =====
// Port-level assertions for the stable time-ordered event queue, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module teq_checker
    import teq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_teq_out o_out
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // A stalled result stays and keeps its payload.
    `TEQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out))

    // Every accepted request produces a result in the next cycle.
    `TEQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_acc, o_out_valid)

    // A taken result with no new request leaves the output empty.
    `TEQ_ASSERT_NEXT(a_no_extra, i_clk, i_rst_n, out_acc && !in_acc, !o_out_valid)

    // A result with a status other than OK carries a zero event payload.
    `TEQ_ASSERT_IMPLY(a_zero_payload, i_clk, i_rst_n,
        o_out_valid && (o_out.status != ST_OK),
        (o_out.out_time == '0) && (o_out.out_kind == '0))

endmodule

bind stable_time_ordered_event_queue teq_checker u_teq_checker (.*);
